// File: hdl/evhs_pkg.sv
package evhs_pkg;

  // Frame header layout, in byte positions counted from zero.
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] DEST_END_POS    = 5'd6;
  localparam logic [POS_W-1:0] SRC_END_POS     = 5'd12;
  localparam logic [POS_W-1:0] BASE_HEADER_END = 5'd13;
  localparam logic [POS_W-1:0] TAG_BYTES       = 5'd4;
  localparam logic [POS_W-1:0] VID_LEAD        = 5'd2;

  // Most stacked tags taken before the next ethertype counts as the payload type.
  localparam logic [1:0] MAX_TAGS = 2'd2;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned VID_W  = 12;
  localparam int unsigned TYPE_W = 16;

  localparam logic [TYPE_W-1:0] VLAN_TAG_TYPE_RESET = 16'h8100;
  localparam logic [VID_W-1:0]  DEFAULT_VID_RESET   = 12'h000;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_RUNT    = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    REG_VLAN_TAG_TYPE      = 2'd0,
    REG_DEFAULT_OUTER_VLAN = 2'd1,
    REG_DEFAULT_INNER_VLAN = 2'd2
  } cfg_reg_t;

endpackage

// File: hdl/ethernet_vlan_header_stripper_top.sv
// Channel  | Handshake             | Fields
// ---------+-----------------------+------------------------------------------------
// frame in | in_valid / in_stall   | frame_byte, frame_end
// result   | out_valid / out_stall | result_kind through payload_type (eight fields)
// config   | cfg_write             | cfg_index, cfg_data
//
// Each accepted byte is parsed in the cycle of its transfer, and its result, if any, is
// held in the output register from the next cycle on.
// One byte is taken per cycle; only a result stalled in the output register stalls the
// input, until that result transfers.
// Reset (rst, synchronous, active high) empties the output register, returns the parser
// to the start of a frame and loads the configuration registers' reset values.
module ethernet_vlan_header_stripper_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    frame_byte,
  input  logic                          frame_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output evhs_pkg::result_kind_t        result_kind,
  output logic [7:0]                    payload_byte,
  output logic                          payload_end,
  output logic [evhs_pkg::MAC_W-1:0]    dest_mac,
  output logic [evhs_pkg::MAC_W-1:0]    src_mac,
  output logic [evhs_pkg::VID_W-1:0]    outer_vlan_id,
  output logic [evhs_pkg::VID_W-1:0]    inner_vlan_id,
  output logic [evhs_pkg::TYPE_W-1:0]   payload_type,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [evhs_pkg::TYPE_W-1:0]   cfg_data
);
  import evhs_pkg::*;

  // Configuration registers.
  logic [TYPE_W-1:0] vlan_tag_type;
  logic [VID_W-1:0]  default_outer_vlan;
  logic [VID_W-1:0]  default_inner_vlan;

  // Parser state. The capture registers need no reset: every bit is written before
  // it can reach a header result.
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [POS_W-1:0]  header_end_position, header_end_position_next;
  logic [1:0]        tags_seen, tags_seen_next;
  logic              in_payload, in_payload_next;
  logic [MAC_W-1:0]  dest_shift, dest_shift_next;
  logic [MAC_W-1:0]  src_shift, src_shift_next;
  logic [TYPE_W-1:0] word_shift, word_shift_next;
  logic [VID_W-1:0]  outer_capture, outer_capture_next;
  logic [VID_W-1:0]  inner_capture, inner_capture_next;

  // Result computed for the byte now being transferred in.
  logic              res_valid;
  result_kind_t      res_kind;
  logic [7:0]        res_byte;
  logic              res_end;
  logic [MAC_W-1:0]  res_dest;
  logic [MAC_W-1:0]  res_src;
  logic [VID_W-1:0]  res_outer;
  logic [VID_W-1:0]  res_inner;
  logic [TYPE_W-1:0] res_type;

  logic in_fire;
  logic out_fire;

  assign out_fire = out_valid & ~out_stall;
  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_tag_type      <= VLAN_TAG_TYPE_RESET;
      default_outer_vlan <= DEFAULT_VID_RESET;
      default_inner_vlan <= DEFAULT_VID_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VLAN_TAG_TYPE:      vlan_tag_type      <= cfg_data;
        REG_DEFAULT_OUTER_VLAN: default_outer_vlan <= cfg_data[VID_W-1:0];
        REG_DEFAULT_INNER_VLAN: default_inner_vlan <= cfg_data[VID_W-1:0];
        default: ;
      endcase
    end
  end

  // One pass over the incoming byte. Header bytes shift into the address and word
  // registers; the end of each tag either extends the header or closes it.
  always_comb begin
    byte_position_next       = byte_position;
    header_end_position_next = header_end_position;
    tags_seen_next           = tags_seen;
    in_payload_next          = in_payload;
    dest_shift_next          = dest_shift;
    src_shift_next           = src_shift;
    word_shift_next          = word_shift;
    outer_capture_next       = outer_capture;
    inner_capture_next       = inner_capture;

    res_valid = 1'b0;
    res_kind  = KIND_HEADER;
    res_byte  = '0;
    res_end   = 1'b0;
    res_dest  = '0;
    res_src   = '0;
    res_outer = '0;
    res_inner = '0;
    res_type  = '0;

    if (in_payload) begin
      res_valid = 1'b1;
      res_kind  = KIND_PAYLOAD;
      res_byte  = frame_byte;
      res_end   = frame_end;
      if (frame_end) begin
        in_payload_next          = 1'b0;
        byte_position_next       = '0;
        header_end_position_next = BASE_HEADER_END;
        tags_seen_next           = '0;
      end
    end else begin
      word_shift_next = {word_shift[7:0], frame_byte};
      if (byte_position < DEST_END_POS) begin
        dest_shift_next = {dest_shift[MAC_W-9:0], frame_byte};
      end else if (byte_position < SRC_END_POS) begin
        src_shift_next = {src_shift[MAC_W-9:0], frame_byte};
      end

      // The tag id word is complete two bytes before the end of its tag.
      if (tags_seen != 2'd0 && byte_position + VID_LEAD == header_end_position) begin
        if (tags_seen == 2'd1) begin
          outer_capture_next = word_shift_next[VID_W-1:0];
        end else begin
          inner_capture_next = word_shift_next[VID_W-1:0];
        end
      end

      if (byte_position == header_end_position &&
          !(word_shift_next == vlan_tag_type && tags_seen < MAX_TAGS)) begin
        res_valid = 1'b1;
        res_kind  = KIND_HEADER;
        res_end   = frame_end;
        res_dest  = dest_shift_next;
        res_src   = src_shift_next;
        res_outer = (tags_seen >= 2'd1) ? outer_capture : default_outer_vlan;
        res_inner = (tags_seen >= 2'd2) ? inner_capture : default_inner_vlan;
        res_type  = word_shift_next;
        if (frame_end) begin
          byte_position_next       = '0;
          header_end_position_next = BASE_HEADER_END;
          tags_seen_next           = '0;
        end else begin
          in_payload_next    = 1'b1;
          byte_position_next = byte_position + 5'd1;
        end
      end else begin
        if (byte_position == header_end_position) begin
          tags_seen_next           = tags_seen + 2'd1;
          header_end_position_next = header_end_position + TAG_BYTES;
        end
        if (frame_end) begin
          // The frame closed inside its header: report a runt and start over.
          res_valid                = 1'b1;
          res_kind                 = KIND_RUNT;
          res_end                  = 1'b1;
          byte_position_next       = '0;
          header_end_position_next = BASE_HEADER_END;
          tags_seen_next           = '0;
        end else begin
          byte_position_next = byte_position + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      header_end_position <= BASE_HEADER_END;
      tags_seen           <= '0;
      in_payload          <= 1'b0;
    end else if (in_fire) begin
      byte_position       <= byte_position_next;
      header_end_position <= header_end_position_next;
      tags_seen           <= tags_seen_next;
      in_payload          <= in_payload_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dest_shift    <= dest_shift_next;
      src_shift     <= src_shift_next;
      word_shift    <= word_shift_next;
      outer_capture <= outer_capture_next;
      inner_capture <= inner_capture_next;
    end
  end

  // Output register: loads on every transfer in, emptied when its result transfers out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      result_kind   <= res_kind;
      payload_byte  <= res_byte;
      payload_end   <= res_end;
      dest_mac      <= res_dest;
      src_mac       <= res_src;
      outer_vlan_id <= res_outer;
      inner_vlan_id <= res_inner;
      payload_type  <= res_type;
    end
  end

  // The header end always sits a whole number of tags past the untagged header.
  a_header_end_tracks_tags: assert property (@(posedge clk) disable iff (rst)
    header_end_position == BASE_HEADER_END + TAG_BYTES * {3'd0, tags_seen} &&
    tags_seen <= MAX_TAGS)
    else $error("header end position out of step with tag count");

  // Once in the payload, the position rests just past the header end.
  a_payload_position: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> byte_position == header_end_position + 5'd1)
    else $error("payload entered at the wrong byte position");

  // A runt result always closes its frame.
  a_runt_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_RUNT |-> payload_end)
    else $error("runt result without end mark");

  // A result that ends a frame leaves the parser at the start of the next one.
  a_end_clears_parser: assert property (@(posedge clk) disable iff (rst)
    in_fire && res_valid && res_end |=> !in_payload && byte_position == '0)
    else $error("parser not cleared after frame end");

endmodule

// File: tb/sv/ethernet_vlan_header_stripper_top_test.sv
module ethernet_vlan_header_stripper_top_test;
  import evhs_pkg::*;

  // A run with a long stretch of cycles in which no transfer happens on any
  // channel has hung. This limit lies far beyond the longest wait between
  // transfers in a correct run.
  localparam int QUIET_LIMIT = 2000;

  // Each phase sends about this many frame bytes of random frames.
  localparam int PHASE_ITEMS = 150;
  localparam int PHASE_COUNT = 6;

  // One frame byte waiting to be driven onto the input channel.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  // One result as the parser should report it.
  typedef struct {
    result_kind_t      kind;
    logic [7:0]        data;
    logic              ends;
    logic [MAC_W-1:0]  dest;
    logic [MAC_W-1:0]  src;
    logic [VID_W-1:0]  outer;
    logic [VID_W-1:0]  inner;
    logic [TYPE_W-1:0] etype;
  } frame_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          frame_byte = 8'h00;
  logic                frame_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  result_kind_t        result_kind;
  logic [7:0]          payload_byte;
  logic                payload_end;
  logic [MAC_W-1:0]    dest_mac;
  logic [MAC_W-1:0]    src_mac;
  logic [VID_W-1:0]    outer_vlan_id;
  logic [VID_W-1:0]    inner_vlan_id;
  logic [TYPE_W-1:0]   payload_type;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = REG_VLAN_TAG_TYPE;
  logic [TYPE_W-1:0]   cfg_data = '0;

  ethernet_vlan_header_stripper_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .frame_byte    (frame_byte),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .payload_end   (payload_end),
    .dest_mac      (dest_mac),
    .src_mac       (src_mac),
    .outer_vlan_id (outer_vlan_id),
    .inner_vlan_id (inner_vlan_id),
    .payload_type  (payload_type),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes that the stimulus has built and the driver has not yet sent, and
  // the results that accepted bytes have produced but the block has not yet
  // delivered.
  wire_byte_t    bytes_to_send[$];
  frame_result_t awaited_results[$];
  logic [7:0]    frame_buf[$];
  wire_byte_t    next_byte;

  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  queued_items = 0;
  int  send_gap = 0;
  int  hold_gap = 0;
  bit  idle_on = 1'b1;
  bit  byte_taken = 1'b0;

  // Our own copy of the configuration registers.
  logic [TYPE_W-1:0] tag_type_cfg;
  logic [VID_W-1:0]  dflt_outer;
  logic [VID_W-1:0]  dflt_inner;

  // Parser state of the header tracker.
  logic [POS_W-1:0]  byte_pos;
  logic [POS_W-1:0]  hdr_end;
  logic [1:0]        tags_taken;
  logic              in_body;
  logic [MAC_W-1:0]  dest_acc;
  logic [MAC_W-1:0]  src_acc;
  logic [TYPE_W-1:0] type_word;
  logic [VID_W-1:0]  outer_acc;
  logic [VID_W-1:0]  inner_acc;

  // Every frame starts from the same parser state, whether it follows reset
  // or the end of the previous frame. The registers are left alone here.
  function automatic void restart_frame();
    byte_pos   = '0;
    hdr_end    = BASE_HEADER_END;
    tags_taken = '0;
    in_body    = 1'b0;
    dest_acc   = '0;
    src_acc    = '0;
    type_word  = '0;
    outer_acc  = '0;
    inner_acc  = '0;
  endfunction

  // Works out what one accepted frame byte makes the block report, if
  // anything, and queues that result.
  function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
    frame_result_t res;
    logic [POS_W-1:0] at;
    at = byte_pos;
    res.kind  = KIND_RUNT;
    res.data  = '0;
    res.ends  = last;
    res.dest  = '0;
    res.src   = '0;
    res.outer = '0;
    res.inner = '0;
    res.etype = '0;

    // Once the header is done, every byte passes straight through.
    if (in_body) begin
      res.kind = KIND_PAYLOAD;
      res.data = b;
      awaited_results.push_back(res);
      if (last) restart_frame();
      return;
    end

    type_word = {type_word[7:0], b};
    if (at < DEST_END_POS) dest_acc = {dest_acc[MAC_W-9:0], b};
    else if (at < SRC_END_POS) src_acc = {src_acc[MAC_W-9:0], b};

    // The id word of a tag is complete two bytes before that tag ends.
    if (tags_taken != 0 && at + VID_LEAD == hdr_end) begin
      if (tags_taken == 1) outer_acc = type_word[VID_W-1:0];
      else inner_acc = type_word[VID_W-1:0];
    end

    if (at == hdr_end) begin
      if (type_word == tag_type_cfg && tags_taken < MAX_TAGS) begin
        // Another tag follows, so the header grows by one tag.
        tags_taken++;
        hdr_end += TAG_BYTES;
      end else begin
        res.kind  = KIND_HEADER;
        res.dest  = dest_acc;
        res.src   = src_acc;
        res.outer = (tags_taken >= 1) ? outer_acc : dflt_outer;
        res.inner = (tags_taken >= 2) ? inner_acc : dflt_inner;
        res.etype = type_word;
        awaited_results.push_back(res);
        if (last) begin
          restart_frame();
        end else begin
          in_body  = 1'b1;
          byte_pos = at + 1'b1;
        end
        return;
      end
    end

    // The frame ended inside its header, which makes it a runt.
    if (last) begin
      awaited_results.push_back(res);
      restart_frame();
      return;
    end
    byte_pos = at + 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [MAC_W-1:0] want,
                                        input logic [MAC_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result of kind %0d arrived with nothing expected", result_kind);
      fail_count++;
      return;
    end
    want = awaited_results.pop_front();
    compare_field("result_kind", want.kind, result_kind);
    compare_field("payload_byte", want.data, payload_byte);
    compare_field("payload_end", want.ends, payload_end);
    compare_field("dest_mac", want.dest, dest_mac);
    compare_field("src_mac", want.src, src_mac);
    compare_field("outer_vlan_id", want.outer, outer_vlan_id);
    compare_field("inner_vlan_id", want.inner, inner_vlan_id);
    compare_field("payload_type", want.etype, payload_type);
  endfunction

  // Monitor. Everything is sampled at the rising edge, where all inputs have
  // been steady since the falling edge. The delivered result is checked
  // before the newly accepted byte is parsed: a byte's result cannot appear
  // in the same cycle as its transfer, so the oldest expectation is always
  // the one that the delivered result answers.
  always @(posedge clk) begin
    byte_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        parse_frame_byte(frame_byte, frame_end);
      end
      if (byte_taken || (out_valid && !out_stall) || cfg_write) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Driver for both handshake sides. A byte stays on the input until its
  // transfer, and only then may the next one (or an idle gap) follow. The
  // result side is stalled in random bursts that are independent of the
  // sender, so stalls land on header, payload and runt results alike.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || byte_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          next_byte = bytes_to_send.pop_front();
          in_valid   <= 1'b1;
          frame_byte <= next_byte.data;
          frame_end  <= next_byte.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        hold_gap = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a long stretch with no transfer at all means the block hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("simulation failed");
    $finish;
  end

  // Hands the bytes in frame_buf to the driver, with the end mark on the
  // final byte.
  task automatic queue_frame();
    wire_byte_t item;
    foreach (frame_buf[i]) begin
      item.data = frame_buf[i];
      item.last = (i == frame_buf.size() - 1);
      bytes_to_send.push_back(item);
    end
    queued_items += frame_buf.size();
    frame_buf.delete();
  endtask

  // MAC bytes lean toward all-zeros and all-ones now and then.
  function automatic logic [7:0] mac_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Most frames are well formed: two MACs, zero to two tags of the current
  // tag type, an ethertype and a payload. Some of them are cut short at a
  // random place, which gives runts and headers that end on the last byte.
  // After two tags the ethertype sometimes equals the tag type again, to
  // check that no third tag is taken. A few frames are pure noise.
  task automatic build_random_frame();
    int tags;
    int body_len;
    int cut;
    logic [TYPE_W-1:0] tag_word;
    logic [TYPE_W-1:0] etype;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
    end else begin
      repeat (12) frame_buf.push_back(mac_byte());
      tags = $urandom_range(0, 2);
      repeat (tags) begin
        tag_word = 16'($urandom);
        frame_buf.push_back(tag_type_cfg[15:8]);
        frame_buf.push_back(tag_type_cfg[7:0]);
        frame_buf.push_back(tag_word[15:8]);
        frame_buf.push_back(tag_word[7:0]);
      end
      etype = 16'($urandom);
      if (tags == 2 && $urandom_range(0, 1) == 1) etype = tag_type_cfg;
      frame_buf.push_back(etype[15:8]);
      frame_buf.push_back(etype[7:0]);
      body_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      repeat (body_len) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
    end
    queue_frame();
  endtask

  // Writes one register. The caller is at a falling edge and lowers the
  // write enable once its last write is done, so back-to-back writes keep
  // the enable high without a glitch.
  task automatic write_register(input cfg_reg_t idx, input logic [TYPE_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_VLAN_TAG_TYPE:      tag_type_cfg = value;
      REG_DEFAULT_OUTER_VLAN: dflt_outer = value[VID_W-1:0];
      REG_DEFAULT_INNER_VLAN: dflt_inner = value[VID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Each phase uses its own register setting; the first four cover the reset values and
  // the extremes, phase 4 random values, and the later ones random default ids.
  task automatic configure_phase(input int ph);
    logic [TYPE_W-1:0] tag_val;
    logic [TYPE_W-1:0] outer_val;
    logic [TYPE_W-1:0] inner_val;
    case (ph)
      0: begin
        tag_val = VLAN_TAG_TYPE_RESET;
        outer_val = DEFAULT_VID_RESET;
        inner_val = DEFAULT_VID_RESET;
      end
      1: begin
        tag_val = 16'h88A8;
        outer_val = 16'h0FFF;
        inner_val = 16'h0FFF;
      end
      2: begin
        tag_val = 16'hFFFF;
        outer_val = 16'h0000;
        inner_val = 16'h0FFF;
      end
      3: begin
        tag_val = 16'h0000;
        outer_val = 16'h0FFF;
        inner_val = 16'h0000;
      end
      4: begin
        tag_val = 16'($urandom);
        outer_val = 16'($urandom);
        inner_val = 16'($urandom);
      end
      default: begin
        tag_val = VLAN_TAG_TYPE_RESET;
        outer_val = 16'($urandom_range(0, 4095));
        inner_val = 16'($urandom_range(0, 4095));
      end
    endcase
    write_register(REG_VLAN_TAG_TYPE, tag_val);
    write_register(REG_DEFAULT_OUTER_VLAN, outer_val);
    write_register(REG_DEFAULT_INNER_VLAN, inner_val);
    cfg_write <= 1'b0;
  endtask

  // Directed frames, sent with the reset register values.
  task automatic send_directed_frames();
    // An untagged header that ends on the frame's last byte, so the header
    // result itself closes the frame. The MACs use all-ones and all-zeros.
    repeat (6) frame_buf.push_back(8'hFF);
    repeat (6) frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h08);
    frame_buf.push_back(8'h00);
    queue_frame();
    // The shortest runt: a single byte that ends the frame.
    frame_buf.push_back(8'h5A);
    queue_frame();
    // A frame that ends on the byte that opens a tag is also a runt.
    repeat (6) frame_buf.push_back(8'h00);
    repeat (6) frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h81);
    frame_buf.push_back(8'h00);
    queue_frame();
  endtask

  // Holds the sender until every queued byte has been sent and every
  // expected result has come, then lets the block settle, since a byte
  // that gives no result may still be inside the block. Checking at the
  // rising edge keeps the test free of races with the driver, which only
  // touches its queue at the falling edge.
  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int target;
    tag_type_cfg = VLAN_TAG_TYPE_RESET;
    dflt_outer = DEFAULT_VID_RESET;
    dflt_inner = DEFAULT_VID_RESET;
    restart_frame();

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers change only between phases, while the block is empty. The
    // sender is paused at every phase boundary until the last result is in.
    // Phase 2 runs without idling on either side, and so does the final
    // phase, so the end of the run goes at full rate.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_on = (ph != 2 && ph != PHASE_COUNT - 1);
      configure_phase(ph);
      if (ph == 0) send_directed_frames();
      target = queued_items + PHASE_ITEMS;
      while (queued_items < target) build_random_frame();
      wait_drained();
    end

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
